### rtl/hbp_pkg.sv
// Types, constants and helper functions shared by the hybrid branch predictor.
package hbp_pkg;

	// Largest index widths of the three counter tables.
	localparam int BIM_BITS = 14;
	localparam int GSH_BITS = 14;
	localparam int CHO_BITS = 14;

	localparam int BIM_DEPTH = 1 << BIM_BITS;
	localparam int GSH_DEPTH = 1 << GSH_BITS;
	localparam int CHO_DEPTH = 1 << CHO_BITS;

	// The clearing sweep covers the deepest table.
	localparam int CLR_BITS_BG = (BIM_BITS > GSH_BITS) ? BIM_BITS : GSH_BITS;
	localparam int CLR_BITS    = (CLR_BITS_BG > CHO_BITS) ? CLR_BITS_BG : CHO_BITS;

	// Width of an effective bit count (holds values up to the largest table width).
	localparam int NB_W = 5;

	// Counter values after reset.
	localparam logic [1:0] BIM_INIT = 2'd2;
	localparam logic [1:0] GSH_INIT = 2'd2;
	localparam logic [1:0] CHO_INIT = 2'd1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_BIM_BITS = 3'd1,
		REG_GSH_BITS = 3'd2,
		REG_HIST_BITS = 3'd3,
		REG_CHO_BITS = 3'd4
	} cfg_idx_t;

	// Predictor selection modes; the unused code behaves as hybrid.
	typedef enum logic [1:0] {
		MODE_BIMODAL = 2'd0,
		MODE_GSHARE  = 2'd1,
		MODE_HYBRID  = 2'd2
	} mode_t;

	// One result word as it waits in the output queue.
	typedef struct packed {
		logic        predict_taken;
		logic        mispredicted;
		logic        used_gshare;
		logic [31:0] predictions_seen;
		logic [31:0] mispredictions_seen;
	} result_t;

	// Forces a configured width into the range one to max_bits.
	function automatic logic [NB_W-1:0] clamp_bits(input logic [3:0] v,
			input logic [NB_W-1:0] max_bits);
		logic [NB_W-1:0] w;
		w = {{(NB_W-4){1'b0}}, v};
		if (w == '0) begin
			return NB_W'(1);
		end else if (w > max_bits) begin
			return max_bits;
		end
		return w;
	endfunction

	// Two-bit saturating counter step toward the outcome.
	function automatic logic [1:0] train(input logic [1:0] c, input logic t);
		if (t) begin
			return (c == 2'd3) ? 2'd3 : c + 2'd1;
		end
		return (c == 2'd0) ? 2'd0 : c - 2'd1;
	endfunction

endpackage

### rtl/hbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered, read-first output.
module hbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/hybrid_branch_predictor.sv
// Top level of the tournament branch predictor (bimodal, gshare and chooser tables).
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, pc, taken              | into      | one resolved branch
//  out     | out_valid, out_ready, predict_taken,       | out of    | prediction, miss flag,
//          | mispredicted, used_gshare,                 |           | component used and the
//          | predictions_seen, mispredictions_seen      |           | two running counts
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | into      | one register write
//
// A branch word can be accepted every cycle while in_ready is high; the tables are read as
// it is accepted, then the read stage updates them and writes its result to the queue.
// After reset a clearing sweep writes every table entry, during which in_ready stays low;
// configuration writes are taken at any time.
// A three-word output queue absorbs stalls on the out channel; in_ready drops
// only when the queue plus the word in flight would overflow it.
module hybrid_branch_predictor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       pc,
	input  logic              taken,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              predict_taken,
	output logic              mispredicted,
	output logic              used_gshare,
	output logic [31:0]       predictions_seen,
	output logic [31:0]       mispredictions_seen,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  hbp_pkg::cfg_idx_t cfg_index,
	input  logic [3:0]        cfg_data
);

	import hbp_pkg::*;

	// Configuration registers.
	logic [1:0] mode_q;
	logic [3:0] bim_bits_q;
	logic [3:0] gsh_bits_q;
	logic [3:0] hist_bits_q;
	logic [3:0] cho_bits_q;

	// Clearing sweep.
	logic [CLR_BITS-1:0] clr_idx_q;
	logic                clr_done_q;

	// Global history.
	logic [GSH_BITS-1:0] hist_q;

	// Read stage.
	logic                s1_valid_s1;
	logic                taken_s1;
	logic [BIM_BITS-1:0] bi_s1;
	logic [GSH_BITS-1:0] gi_s1;
	logic [CHO_BITS-1:0] ci_s1;

	// Last write of each table, for forwarding to the next word.
	logic                bim_fwd_v_q, gsh_fwd_v_q, cho_fwd_v_q;
	logic [BIM_BITS-1:0] bim_fwd_a_q;
	logic [GSH_BITS-1:0] gsh_fwd_a_q;
	logic [CHO_BITS-1:0] cho_fwd_a_q;
	logic [1:0]          bim_fwd_d_q, gsh_fwd_d_q, cho_fwd_d_q;

	// Running counts.
	logic [31:0] branch_total_q;
	logic [31:0] miss_total_q;

	// Output queue.
	result_t    fifo_q [3];
	logic [1:0] fifo_cnt_q;
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;

	// Combinational signals.
	logic                accept;
	logic [NB_W-1:0]     bb, gb, cb, hb;
	logic [29:0]         word;
	logic [BIM_BITS-1:0] bim_mask, bi_next;
	logic [GSH_BITS-1:0] gsh_mask, hmask, hist_m, gi_next, hist_next;
	logic [CHO_BITS-1:0] cho_mask, ci_next;
	logic [1:0]          bim_rd, gsh_rd, cho_rd;
	logic [1:0]          bim_cur, gsh_cur, cho_cur;
	logic [1:0]          bim_new, gsh_new, cho_new;
	logic                bpred, gpred, use_g, pred, miss;
	logic                bim_upd, gsh_upd, cho_upd;
	logic                bim_we, gsh_we, cho_we;
	logic [BIM_BITS-1:0] bim_wa;
	logic [GSH_BITS-1:0] gsh_wa;
	logic [CHO_BITS-1:0] cho_wa;
	logic [1:0]          bim_wd, gsh_wd, cho_wd;
	logic [31:0]         branch_total_next, miss_total_next;
	logic [2:0]          in_flight;
	logic                fifo_rd;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HYBRID;
			bim_bits_q  <= 4'd14;
			gsh_bits_q  <= 4'd14;
			hist_bits_q <= 4'd8;
			cho_bits_q  <= 4'd14;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[1:0];
				REG_BIM_BITS:  bim_bits_q  <= cfg_data;
				REG_GSH_BITS:  gsh_bits_q  <= cfg_data;
				REG_HIST_BITS: hist_bits_q <= cfg_data;
				REG_CHO_BITS:  cho_bits_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective widths and the table indexes of the incoming branch.
	always_comb begin
		bb       = clamp_bits(bim_bits_q, NB_W'(BIM_BITS));
		gb       = clamp_bits(gsh_bits_q, NB_W'(GSH_BITS));
		cb       = clamp_bits(cho_bits_q, NB_W'(CHO_BITS));
		hb       = ({1'b0, hist_bits_q} > gb) ? gb : {1'b0, hist_bits_q};
		bim_mask = ~({BIM_BITS{1'b1}} << bb);
		gsh_mask = ~({GSH_BITS{1'b1}} << gb);
		cho_mask = ~({CHO_BITS{1'b1}} << cb);
		hmask    = ~({GSH_BITS{1'b1}} << hb);
		hist_m   = hist_q & hmask;
		word     = pc[31:2];
		bi_next  = word[BIM_BITS-1:0] & bim_mask;
		gi_next  = (word[GSH_BITS-1:0] & gsh_mask) ^ (hist_m << (gb - hb));
		ci_next  = word[CHO_BITS-1:0] & cho_mask;
		if (hb == '0) begin
			hist_next = '0;
		end else begin
			hist_next = ((hist_m >> 1) | (GSH_BITS'(taken) << (hb - NB_W'(1)))) & hmask;
		end
	end

	// History depends only on outcomes, so it moves as each word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (accept) begin
			hist_q <= hist_next;
		end
	end

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + CLR_BITS'(1);
			if (clr_idx_q == {CLR_BITS{1'b1}}) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Read stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_s1 <= taken;
			bi_s1    <= bi_next;
			gi_s1    <= gi_next;
			ci_s1    <= ci_next;
		end
	end

	// Counter tables.
	hbp_ram #(.WIDTH(2), .DEPTH(BIM_DEPTH)) u_bim_ram (
		.clk   (clk),
		.we    (bim_we),
		.waddr (bim_wa),
		.wdata (bim_wd),
		.raddr (bi_next),
		.rdata (bim_rd)
	);

	hbp_ram #(.WIDTH(2), .DEPTH(GSH_DEPTH)) u_gsh_ram (
		.clk   (clk),
		.we    (gsh_we),
		.waddr (gsh_wa),
		.wdata (gsh_wd),
		.raddr (gi_next),
		.rdata (gsh_rd)
	);

	hbp_ram #(.WIDTH(2), .DEPTH(CHO_DEPTH)) u_cho_ram (
		.clk   (clk),
		.we    (cho_we),
		.waddr (cho_wa),
		.wdata (cho_wd),
		.raddr (ci_next),
		.rdata (cho_rd)
	);

	// Prediction, training and the chooser update for the word in the read stage.
	always_comb begin
		// The previous word's write lands on the same edge as this word's read.
		bim_cur = (bim_fwd_v_q && bim_fwd_a_q == bi_s1) ? bim_fwd_d_q : bim_rd;
		gsh_cur = (gsh_fwd_v_q && gsh_fwd_a_q == gi_s1) ? gsh_fwd_d_q : gsh_rd;
		cho_cur = (cho_fwd_v_q && cho_fwd_a_q == ci_s1) ? cho_fwd_d_q : cho_rd;
		bpred   = bim_cur[1];
		gpred   = gsh_cur[1];
		case (mode_t'(mode_q))
			MODE_BIMODAL: use_g = 1'b0;
			MODE_GSHARE:  use_g = 1'b1;
			default:      use_g = cho_cur[1];
		endcase
		pred    = use_g ? gpred : bpred;
		miss    = pred != taken_s1;
		bim_new = train(bim_cur, taken_s1);
		gsh_new = train(gsh_cur, taken_s1);
		cho_new = train(cho_cur, gpred == taken_s1);
		bim_upd = s1_valid_s1 && !use_g;
		gsh_upd = s1_valid_s1 && use_g;
		cho_upd = s1_valid_s1 && mode_q[1] && ((gpred == taken_s1) != (bpred == taken_s1));

		// The clearing sweep owns the write ports until it finishes.
		bim_we = !clr_done_q || bim_upd;
		gsh_we = !clr_done_q || gsh_upd;
		cho_we = !clr_done_q || cho_upd;
		bim_wa = clr_done_q ? bi_s1 : clr_idx_q[BIM_BITS-1:0];
		gsh_wa = clr_done_q ? gi_s1 : clr_idx_q[GSH_BITS-1:0];
		cho_wa = clr_done_q ? ci_s1 : clr_idx_q[CHO_BITS-1:0];
		bim_wd = clr_done_q ? bim_new : BIM_INIT;
		gsh_wd = clr_done_q ? gsh_new : GSH_INIT;
		cho_wd = clr_done_q ? cho_new : CHO_INIT;

		branch_total_next = branch_total_q + 32'd1;
		miss_total_next   = miss_total_q + {31'd0, miss};
	end

	// Forwarding registers hold the last update of each table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bim_fwd_v_q <= 1'b0;
			gsh_fwd_v_q <= 1'b0;
			cho_fwd_v_q <= 1'b0;
		end else begin
			bim_fwd_v_q <= bim_upd;
			gsh_fwd_v_q <= gsh_upd;
			cho_fwd_v_q <= cho_upd;
		end
	end

	always_ff @(posedge clk) begin
		bim_fwd_a_q <= bi_s1;
		gsh_fwd_a_q <= gi_s1;
		cho_fwd_a_q <= ci_s1;
		bim_fwd_d_q <= bim_new;
		gsh_fwd_d_q <= gsh_new;
		cho_fwd_d_q <= cho_new;
	end

	// Running counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			branch_total_q <= '0;
			miss_total_q   <= '0;
		end else if (s1_valid_s1) begin
			branch_total_q <= branch_total_next;
			miss_total_q   <= miss_total_next;
		end
	end

	// Output queue: the read stage pushes, the out channel pops.
	assign fifo_rd   = out_valid && out_ready;
	assign in_flight = {1'b0, fifo_cnt_q} + {2'b00, s1_valid_s1};
	assign in_ready  = clr_done_q && (in_flight < 3'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
		end else begin
			if (s1_valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (fifo_rd) begin
				rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			if (s1_valid_s1 && !fifo_rd) begin
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			end else if (!s1_valid_s1 && fifo_rd) begin
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			fifo_q[wr_ptr_q] <= '{
				predict_taken:       pred,
				mispredicted:        miss,
				used_gshare:         use_g,
				predictions_seen:    branch_total_next,
				mispredictions_seen: miss_total_next
			};
		end
	end

	assign out_valid           = fifo_cnt_q != 2'd0;
	assign predict_taken       = fifo_q[rd_ptr_q].predict_taken;
	assign mispredicted        = fifo_q[rd_ptr_q].mispredicted;
	assign used_gshare         = fifo_q[rd_ptr_q].used_gshare;
	assign predictions_seen    = fifo_q[rd_ptr_q].predictions_seen;
	assign mispredictions_seen = fifo_q[rd_ptr_q].mispredictions_seen;

	// The queue never has to take a word it has no room for.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= 3'd3)
		else $error("output queue overflow");

	// Once the sweep has finished it never restarts.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		clr_done_q |=> clr_done_q)
		else $error("clearing sweep restarted");

	// Each word leaving the read stage advances the branch count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |=> branch_total_q == $past(branch_total_q) + 32'd1)
		else $error("branch count did not advance");

	// A forwarded write always comes from a word that was in the read stage.
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		(bim_fwd_v_q || gsh_fwd_v_q || cho_fwd_v_q) |-> $past(s1_valid_s1))
		else $error("forwarding without a word in flight");

endmodule

### test/tb_hybrid_branch_predictor.sv
// Self-checking testbench for the hybrid branch predictor with a shadow table model.
module tb_hybrid_branch_predictor;
	timeunit 1ns;
	timeprecision 1ps;

	import hbp_pkg::*;

	// Habits of the hot branches that make up the program-like trace.
	typedef enum int {
		HABIT_TAKEN,
		HABIT_NOT_TAKEN,
		HABIT_LOOP,
		HABIT_ALTERNATE,
		HABIT_COIN
	} habit_t;

	typedef struct {
		logic [31:0] addr;
		logic        outcome;
	} branch_t;

	localparam logic [1:0] LEAN_TAKEN = 2'd2;
	localparam logic [3:0] MODE_SPARE = 4'd3;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int HOT_COUNT = 16;
	localparam int LONG_HOLD = 300;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] pc = '0;
	logic taken = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic predict_taken;
	logic mispredicted;
	logic used_gshare;
	logic [31:0] predictions_seen;
	logic [31:0] mispredictions_seen;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = REG_MODE;
	logic [3:0] cfg_data = '0;

	hybrid_branch_predictor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pc(pc),
		.taken(taken),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.predict_taken(predict_taken),
		.mispredicted(mispredicted),
		.used_gshare(used_gshare),
		.predictions_seen(predictions_seen),
		.mispredictions_seen(mispredictions_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the predictor state and its registers.
	logic [1:0] bim_table [BIM_DEPTH];
	logic [1:0] gsh_table [GSH_DEPTH];
	logic [1:0] cho_table [CHO_DEPTH];
	int unsigned ghist;
	logic [31:0] branch_count;
	logic [31:0] miss_count;
	logic [1:0] sel_mode;
	logic [3:0] bim_bits;
	logic [3:0] gsh_bits;
	logic [3:0] hist_bits;
	logic [3:0] cho_bits;

	branch_t branch_queue[$];
	result_t predicted_outcomes[$];
	int mismatch_count = 0;
	int result_index = 0;
	logic no_gaps = 1'b0;
	logic hold_request = 1'b0;
	logic out_hold = 1'b0;

	// Hot branch set of the current phase.
	logic [31:0] hot_pc [HOT_COUNT];
	habit_t hot_habit [HOT_COUNT];
	int hot_len [HOT_COUNT];
	int hot_pos [HOT_COUNT];
	int hot_walk = 0;

	// A width of zero counts as one; anything above the table size counts as the table size.
	function automatic int unsigned eff_width(input logic [3:0] v, input int unsigned limit);
		if (v == 4'd0) begin
			return 1;
		end
		return (v > limit) ? limit : v;
	endfunction

	// Two-bit saturating counter moved one step toward the outcome.
	function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
		if (up) begin
			return (c == 2'd3) ? c : c + 2'd1;
		end
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// Predicts one branch, trains the shadow tables and returns the result word.
	function automatic result_t predict_branch(input logic [31:0] br_pc, input logic outcome);
		int unsigned addr, bw, gw, cw, hw, hmask, hist, bi, gi, ci;
		logic bim_says, gsh_says, via_gsh, guess;
		result_t r;
		addr = br_pc >> 2;
		bw = eff_width(bim_bits, BIM_BITS);
		gw = eff_width(gsh_bits, GSH_BITS);
		cw = eff_width(cho_bits, CHO_BITS);
		hw = (hist_bits > gw) ? gw : hist_bits;
		hmask = (32'd1 << hw) - 32'd1;
		hist = ghist & hmask;
		bi = addr & ((32'd1 << bw) - 32'd1);
		gi = (addr & ((32'd1 << gw) - 32'd1)) ^ (hist << (gw - hw));
		ci = addr & ((32'd1 << cw) - 32'd1);
		bim_says = bim_table[bi] >= LEAN_TAKEN;
		gsh_says = gsh_table[gi] >= LEAN_TAKEN;
		case (sel_mode)
			MODE_BIMODAL: via_gsh = 1'b0;
			MODE_GSHARE: via_gsh = 1'b1;
			default: via_gsh = cho_table[ci] >= LEAN_TAKEN;
		endcase
		guess = via_gsh ? gsh_says : bim_says;

		// Only the component that was used learns from the outcome.
		if (via_gsh) begin
			gsh_table[gi] = sat_step(gsh_table[gi], outcome);
		end else begin
			bim_table[bi] = sat_step(bim_table[bi], outcome);
		end

		// The chooser moves only when exactly one component was right.
		if (sel_mode >= MODE_HYBRID && (gsh_says == outcome) != (bim_says == outcome)) begin
			cho_table[ci] = sat_step(cho_table[ci], gsh_says == outcome);
		end

		// The history shifts right with the newest outcome entering at the top.
		if (hw == 0) begin
			ghist = 0;
		end else begin
			ghist = ((hist >> 1) | (int'(outcome) << (hw - 1))) & hmask;
		end

		branch_count = branch_count + 32'd1;
		if (guess != outcome) begin
			miss_count = miss_count + 32'd1;
		end
		r.predict_taken = guess;
		r.mispredicted = guess != outcome;
		r.used_gshare = via_gsh;
		r.predictions_seen = branch_count;
		r.mispredictions_seen = miss_count;
		return r;
	endfunction

	// Input driver: offers the oldest pending branch and predicts it once it is taken.
	always @(posedge clk) begin
		logic fire;
		logic go;
		fire = in_valid && in_ready;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (fire) begin
				predicted_outcomes.push_back(predict_branch(branch_queue[0].addr,
						branch_queue[0].outcome));
				branch_queue.pop_front();
			end
			if (!in_valid || fire) begin
				go = branch_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 6);
				in_valid <= go;
				if (go) begin
					pc <= branch_queue[0].addr;
					taken <= branch_queue[0].outcome;
				end
			end
		end
	end

	// Output monitor: compares each result word with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		logic bad;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("result word %0d arrived with no prediction waiting",
								result_index);
					end
				end else begin
					want = predicted_outcomes.pop_front();
					bad = (predict_taken !== want.predict_taken)
							|| (mispredicted !== want.mispredicted)
							|| (used_gshare !== want.used_gshare)
							|| (predictions_seen !== want.predictions_seen)
							|| (mispredictions_seen !== want.mispredictions_seen);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("word %0d expected taken=%b miss=%b gshare=%b seen=%0d missed=%0d",
									result_index, want.predict_taken, want.mispredicted,
									want.used_gshare, want.predictions_seen,
									want.mispredictions_seen);
							$display("word %0d got      taken=%b miss=%b gshare=%b seen=%0d missed=%0d",
									result_index, predict_taken, mispredicted, used_gshare,
									predictions_seen, mispredictions_seen);
						end
					end
				end
				result_index++;
			end
			out_ready <= !out_hold && (no_gaps || $urandom_range(99) >= 6);
		end
	end

	// Long receiver stall, counted here, so the block backs up and drops in_ready.
	initial begin
		wait (hold_request);
		@(posedge clk);
		out_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		out_hold <= 1'b0;
	end

	// Watchdog.
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Waits until every branch has been sent and every result word has come back.
	task automatic wait_idle();
		while (branch_queue.size() != 0 || in_valid || predicted_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	// One register write on the configuration channel, mirrored into the shadow copy.
	task automatic write_reg(input cfg_idx_t idx, input logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE: sel_mode = val[1:0];
			REG_BIM_BITS: bim_bits = val;
			REG_GSH_BITS: gsh_bits = val;
			REG_HIST_BITS: hist_bits = val;
			REG_CHO_BITS: cho_bits = val;
			default: ;
		endcase
	endtask

	// New hot branch set; the upper half aliases the lower half in the low address bits.
	task automatic pick_hot_set();
		for (int k = 0; k < HOT_COUNT; k++) begin
			hot_pc[k] = $urandom;
			if (k >= HOT_COUNT / 2) begin
				hot_pc[k][15:0] = hot_pc[k - HOT_COUNT / 2][15:0];
			end
			hot_habit[k] = habit_t'($urandom_range(HABIT_COIN));
			hot_len[k] = $urandom_range(2, 9);
			hot_pos[k] = 0;
		end
	endtask

	// Mostly a program-like trace of hot branches, with some random noise mixed in.
	task automatic queue_branches(input int n);
		branch_t b;
		int sel;
		int k;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 12) begin
				b.addr = $urandom;
				b.outcome = 1'($urandom_range(1));
			end else begin
				if (sel < 45) begin
					k = hot_walk % HOT_COUNT;
					hot_walk++;
				end else begin
					k = $urandom_range(HOT_COUNT - 1);
				end
				b.addr = hot_pc[k];
				hot_pos[k]++;
				case (hot_habit[k])
					HABIT_TAKEN: b.outcome = $urandom_range(19) != 0;
					HABIT_NOT_TAKEN: b.outcome = $urandom_range(19) == 0;
					HABIT_LOOP: b.outcome = (hot_pos[k] % hot_len[k]) != 0;
					HABIT_ALTERNATE: b.outcome = hot_pos[k][0];
					default: b.outcome = 1'($urandom_range(1));
				endcase
			end
			branch_queue.push_back(b);
		end
	endtask

	// Reprograms every register between phases, then sends one phase of branches.
	task automatic run_phase(input logic [3:0] m, input logic [3:0] bw, input logic [3:0] gw,
			input logic [3:0] hw, input logic [3:0] cw, input int n, input logic hold);
		wait_idle();
		write_reg(REG_MODE, m);
		write_reg(REG_BIM_BITS, bw);
		write_reg(REG_GSH_BITS, gw);
		write_reg(REG_HIST_BITS, hw);
		write_reg(REG_CHO_BITS, cw);
		pick_hot_set();
		if (hold) begin
			// Back-to-back words on both sides while the receiver stalls for a long stretch.
			no_gaps = 1'b1;
			queue_branches(n);
			hold_request = 1'b1;
			wait_idle();
			no_gaps = 1'b0;
		end else begin
			// The sender pauses halfway until every result word is back.
			queue_branches(n / 2);
			wait_idle();
			queue_branches(n - n / 2);
		end
	endtask

	// Directed branches, then phases under changing register settings.
	initial begin
		branch_t b;
		logic [31:0] edge_pc [20];
		logic edge_dir [20];
		for (int i = 0; i < BIM_DEPTH; i++) begin
			bim_table[i] = BIM_INIT;
		end
		for (int i = 0; i < GSH_DEPTH; i++) begin
			gsh_table[i] = GSH_INIT;
		end
		for (int i = 0; i < CHO_DEPTH; i++) begin
			cho_table[i] = CHO_INIT;
		end
		ghist = 0;
		branch_count = '0;
		miss_count = '0;
		sel_mode = MODE_HYBRID;
		bim_bits = 4'd14;
		gsh_bits = 4'd14;
		hist_bits = 4'd8;
		cho_bits = 4'd14;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Saturate one counter both ways, hit the address extremes, ignored low bits,
		// aliasing above the index, and an alternating branch that moves the chooser.
		edge_pc = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
				32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_0003, 32'h0001_0000,
				32'h8000_0004, 32'h8000_0004,
				32'h40, 32'h40, 32'h40, 32'h40, 32'h40, 32'h40};
		edge_dir = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
				1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
				1'b1, 1'b1,
				1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		for (int i = 0; i < 20; i++) begin
			b.addr = edge_pc[i];
			b.outcome = edge_dir[i];
			branch_queue.push_back(b);
		end

		// Reset settings.
		pick_hot_set();
		queue_branches(100);
		wait_idle();
		queue_branches(100);

		// Bimodal only; widths of zero and fifteen, history longer than the gshare index.
		run_phase({2'b00, MODE_BIMODAL}, 4'd0, 4'd15, 4'd15, 4'd0, 200, 1'b0);
		// Gshare only with a short index and clamped history.
		run_phase({2'b00, MODE_GSHARE}, 4'd14, 4'd4, 4'd9, 4'd14, 200, 1'b0);
		// The spare mode code, a one-bit gshare index and no history.
		run_phase(MODE_SPARE, 4'd3, 4'd1, 4'd0, 4'd2, 200, 1'b0);
		// Hybrid under a long receiver stall.
		run_phase({2'b00, MODE_HYBRID}, 4'd10, 4'd12, 4'd12, 4'd8, 300, 1'b1);

		// A write to an undefined register index must change nothing.
		wait_idle();
		write_reg(cfg_idx_t'(REG_SPARE), 4'b1111);
		// Upper mode bits set, a gshare width of zero with one history bit.
		run_phase(4'b1110, 4'd15, 4'd0, 4'd1, 4'd15, 200, 1'b0);

		// Random settings.
		repeat (2) begin
			run_phase(4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)), 200, 1'b0);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
